// File: sv/mvt_pkg.sv
// shared constants and types of the matrix-vector transform unit
// no dependencies; used by every other file of the block
package mvt_pkg;

    localparam int VALUE_WIDTH = 32;   // default total bits of an entry or component
    localparam int FRAC_BITS   = 16;   // default fraction bits
    localparam int FIELD_W     = 32;   // width of every item field
    localparam int REG_W       = 64;   // width of a configuration register
    localparam int HALF_W      = 32;   // one matrix entry per register half
    localparam int NUM_REGS    = 8;
    localparam int CFG_IDX_W   = $clog2(NUM_REGS);
    localparam int DIM         = 4;    // matrix rows, vector components
    localparam int PIPE_DEPTH  = 5;    // input, product, pair sum, total, saturate

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [REG_W-1:0]   t_cfg_word;

    // register indexes, in the order of the register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_LEFT  = 3'd0,
        REG_ROW0_RIGHT = 3'd1,
        REG_ROW1_LEFT  = 3'd2,
        REG_ROW1_RIGHT = 3'd3,
        REG_ROW2_LEFT  = 3'd4,
        REG_ROW2_RIGHT = 3'd5,
        REG_ROW3_LEFT  = 3'd6,
        REG_ROW3_RIGHT = 3'd7
    } t_reg_idx;

endpackage

// File: sv/mvt_in_if.sv
// input channel of the transform unit: one vector per item
// depends on mvt_pkg for the field type
interface mvt_in_if;
    logic            valid;
    logic            ready;
    mvt_pkg::t_field vec_x;
    mvt_pkg::t_field vec_y;
    mvt_pkg::t_field vec_z;
    mvt_pkg::t_field vec_w;

    modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                    input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                    output ready);
endinterface

// File: sv/mvt_out_if.sv
// output channel of the transform unit: one transformed vector per item
// depends on mvt_pkg for the field type
interface mvt_out_if;
    logic            valid;
    logic            ready;
    mvt_pkg::t_field out_x;
    mvt_pkg::t_field out_y;
    mvt_pkg::t_field out_z;
    mvt_pkg::t_field out_w;

    modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                    input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                    output ready);
endinterface

// File: sv/mvt_cfg_regs.sv
// matrix register file: eight 64-bit registers, two entries each, identity at reset
// depends on mvt_pkg
module mvt_cfg_regs #(
    parameter int VALUE_WIDTH = mvt_pkg::VALUE_WIDTH,
    parameter int FRAC_BITS   = mvt_pkg::FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  mvt_pkg::t_cfg_word                     i_cfg_data,
    output logic [mvt_pkg::DIM-1:0][mvt_pkg::DIM-1:0][VALUE_WIDTH-1:0] o_mat
);

    localparam logic [mvt_pkg::HALF_W-1:0] ONE =
        mvt_pkg::HALF_W'(64'd1 << FRAC_BITS);
    localparam mvt_pkg::t_cfg_word DIAG_LO = {{mvt_pkg::HALF_W{1'b0}}, ONE};
    localparam mvt_pkg::t_cfg_word DIAG_HI = {ONE, {mvt_pkg::HALF_W{1'b0}}};

    mvt_pkg::t_cfg_word r_mat [mvt_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mvt_pkg::NUM_REGS; i++) begin
                r_mat[i] <= '0;
            end
            r_mat[mvt_pkg::REG_ROW0_LEFT]  <= DIAG_LO;
            r_mat[mvt_pkg::REG_ROW1_LEFT]  <= DIAG_HI;
            r_mat[mvt_pkg::REG_ROW2_RIGHT] <= DIAG_LO;
            r_mat[mvt_pkg::REG_ROW3_RIGHT] <= DIAG_HI;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    // entry 4r+c sits in register (4r+c)/2, low half for even c
    always_comb begin
        for (int r = 0; r < mvt_pkg::DIM; r++) begin
            for (int c = 0; c < mvt_pkg::DIM; c++) begin
                o_mat[r][c] = r_mat[(r * mvt_pkg::DIM + c) / 2]
                                   [(c % 2) * mvt_pkg::HALF_W +: VALUE_WIDTH];
            end
        end
    end

endmodule

// File: sv/mvt_dot_row.sv
// one matrix row dotted with the vector: multiply, pair sum, total, shift and saturate
// depends on mvt_pkg; pipeline enable comes from the top level
module mvt_dot_row #(
    parameter int VALUE_WIDTH = mvt_pkg::VALUE_WIDTH,
    parameter int FRAC_BITS   = mvt_pkg::FRAC_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic [mvt_pkg::DIM-1:0][VALUE_WIDTH-1:0]   i_row,
    input  logic [mvt_pkg::DIM-1:0][VALUE_WIDTH-1:0]   i_vec,
    output logic [VALUE_WIDTH-1:0]                     o_res
);

    localparam int PW = 2 * VALUE_WIDTH;   // exact product
    localparam int AW = PW + 1;            // sum of two products
    localparam int SW = PW + 2;            // sum of four products
    localparam logic signed [SW-1:0] MAXV =
        SW'(signed'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1));
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    logic signed [PW-1:0] r_prod [mvt_pkg::DIM];
    logic signed [AW-1:0] r_pair [2];
    logic signed [SW-1:0] r_sum;
    logic [VALUE_WIDTH-1:0] r_res;

    logic signed [SW-1:0]   w_shift;
    logic [VALUE_WIDTH-1:0] n_res;

    always_comb begin
        w_shift = r_sum >>> FRAC_BITS;
        if (w_shift > MAXV) begin
            n_res = MAXV[VALUE_WIDTH-1:0];
        end else if (w_shift < MINV) begin
            n_res = MINV[VALUE_WIDTH-1:0];
        end else begin
            n_res = w_shift[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < mvt_pkg::DIM; c++) begin
                r_prod[c] <= $signed(i_row[c]) * $signed(i_vec[c]);
            end
            r_pair[0] <= AW'(r_prod[0]) + AW'(r_prod[1]);
            r_pair[1] <= AW'(r_prod[2]) + AW'(r_prod[3]);
            r_sum     <= SW'(r_pair[0]) + SW'(r_pair[1]);
            r_res     <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: sv/matrix_vector_transform_unit.sv
// throughput: one item per cycle; the pipeline stalls as a whole only while a result waits
// reset: synchronous active low, clears all valid bits and loads the identity matrix
// stages: input register, 16 multipliers, pair sums, row totals, shift and saturate
// the matrix is read live by the multipliers, so write it only while the unit is empty
module matrix_vector_transform_unit #(
    parameter int VALUE_WIDTH = mvt_pkg::VALUE_WIDTH,
    parameter int FRAC_BITS   = mvt_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  mvt_pkg::t_cfg_word            i_cfg_data,
    mvt_in_if.sink                        i_vec,
    mvt_out_if.source                     o_res
);

    localparam int D = mvt_pkg::DIM;

    // matrix entries, row by row, low VALUE_WIDTH bits of each half
    logic [D-1:0][D-1:0][VALUE_WIDTH-1:0] w_mat;

    // valid bit for each pipeline stage; the last one is the output register
    logic [mvt_pkg::PIPE_DEPTH-1:0] r_vld;

    // input vector register, truncated to the working width
    logic [D-1:0][VALUE_WIDTH-1:0] r_vec;

    logic [D-1:0][VALUE_WIDTH-1:0] w_res;

    // whole pipeline moves unless a result sits unclaimed in the output register
    logic w_en;

    assign w_en        = !r_vld[mvt_pkg::PIPE_DEPTH-1] || o_res.ready;
    assign i_vec.ready = w_en;

    mvt_cfg_regs #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_mat      (w_mat)
    );

    // valid bits march alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[mvt_pkg::PIPE_DEPTH-2:0], i_vec.valid};
        end
    end

    // input stage, payload only
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vec[0] <= i_vec.vec_x[VALUE_WIDTH-1:0];
            r_vec[1] <= i_vec.vec_y[VALUE_WIDTH-1:0];
            r_vec[2] <= i_vec.vec_z[VALUE_WIDTH-1:0];
            r_vec[3] <= i_vec.vec_w[VALUE_WIDTH-1:0];
        end
    end

    // one dot-product lane per output component
    for (genvar r = 0; r < D; r++) begin : g_row
        mvt_dot_row #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_row (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_row (w_mat[r]),
            .i_vec (r_vec),
            .o_res (w_res[r])
        );
    end

    // results leave sign-extended to the field width
    assign o_res.valid = r_vld[mvt_pkg::PIPE_DEPTH-1];
    assign o_res.out_x = mvt_pkg::FIELD_W'($signed(w_res[0]));
    assign o_res.out_y = mvt_pkg::FIELD_W'($signed(w_res[1]));
    assign o_res.out_z = mvt_pkg::FIELD_W'($signed(w_res[2]));
    assign o_res.out_w = mvt_pkg::FIELD_W'($signed(w_res[3]));

endmodule
